@@ hdl/utf8dw_pkg.sv @@
// Shared types, constants and the display-width classifier for the UTF-8
// decoder. No dependencies; used by the result channel interface and the top level.
`default_nettype none

package utf8dw_pkg;

  localparam int CpW  = 21;
  localparam int TotW = 32;
  localparam int PartW = 15;

  typedef logic [CpW-1:0]  cp_t;
  typedef logic [TotW-1:0] tot_t;
  typedef logic [1:0]      col_t;
  typedef logic [2:0]      seq_len_t;

  // Sequence length codes
  localparam seq_len_t LEN_NONE = 3'd0;
  localparam seq_len_t LEN_TWO  = 3'd2;
  localparam seq_len_t LEN_THREE = 3'd3;
  localparam seq_len_t LEN_FOUR = 3'd4;

  localparam cp_t CP_REPL    = 21'h00FFFD;
  localparam cp_t CP_MAX     = 21'h10FFFF;
  localparam cp_t CP_SURR_LO = 21'h00D800;
  localparam cp_t CP_SURR_HI = 21'h00DFFF;
  localparam cp_t CP_MIN2    = 21'h000080;
  localparam cp_t CP_MIN3    = 21'h000800;
  localparam cp_t CP_MIN4    = 21'h010000;

  localparam col_t COL_ZERO = 2'd0;
  localparam col_t COL_ONE  = 2'd1;
  localparam col_t COL_TWO  = 2'd2;

  localparam int NZero = 11;
  localparam int NWide = 12;

  localparam cp_t ZERO_LO [NZero] = '{
    21'h0000, 21'h007F, 21'h0300, 21'h1AB0, 21'h1DC0, 21'h200B,
    21'h2060, 21'h20D0, 21'hFE0E, 21'hFE20, 21'hFEFF};
  localparam cp_t ZERO_HI [NZero] = '{
    21'h001F, 21'h009F, 21'h036F, 21'h1AFF, 21'h1DFF, 21'h200D,
    21'h2060, 21'h20FF, 21'hFE0F, 21'hFE2F, 21'hFEFF};

  localparam cp_t WIDE_LO [NWide] = '{
    21'h02E80, 21'h02FF0, 21'h0A960, 21'h0AC00, 21'h0F900, 21'h0FE10,
    21'h0FE30, 21'h0FF00, 21'h0FFE0, 21'h1F100, 21'h1F300, 21'h20000};
  localparam cp_t WIDE_HI [NWide] = '{
    21'h02FDF, 21'h0A4CF, 21'h0A97F, 21'h0D7FF, 21'h0FAFF, 21'h0FE1F,
    21'h0FE6F, 21'h0FF60, 21'h0FFE6, 21'h1F1FF, 21'h1FBFF, 21'h3FFFF};

  // Zero-width ranges win over wide ranges; everything else is one column.
  function automatic col_t col_class(input cp_t cp);
    logic zero_hit;
    logic wide_hit;
    zero_hit = 1'b0;
    wide_hit = 1'b0;
    for (int i = 0; i < NZero; i++) begin
      if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]) zero_hit = 1'b1;
    end
    for (int j = 0; j < NWide; j++) begin
      if (cp >= WIDE_LO[j] && cp <= WIDE_HI[j]) wide_hit = 1'b1;
    end
    if (zero_hit) return COL_ZERO;
    if (wide_hit) return COL_TWO;
    return COL_ONE;
  endfunction

endpackage

`default_nettype wire

@@ hdl/utf8dw_in_if.sv @@
// Byte input channel of the UTF-8 decoder: valid/ready plus one byte word.
// No dependencies.
`default_nettype none

interface utf8dw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

@@ hdl/utf8dw_out_if.sv @@
// Result channel of the UTF-8 decoder: valid/ready plus one decoded word.
// Depends on utf8dw_pkg for payload widths.
`default_nettype none

interface utf8dw_out_if;
  logic               valid;
  logic               ready;
  utf8dw_pkg::cp_t    code_point;
  logic               replaced;
  utf8dw_pkg::col_t   column_width;
  utf8dw_pkg::tot_t   col_total;
  logic               string_done;

  modport source (output valid, output code_point, output replaced, output column_width,
                  output col_total, output string_done, input ready);
  modport sink   (input valid, input code_point, input replaced, input column_width,
                  input col_total, input string_done, output ready);
endinterface

`default_nettype wire

@@ hdl/utf8_decode_display_width.sv @@
// UTF-8 decoder with display-width accumulation, top level.
// Depends on utf8dw_pkg, utf8dw_in_if and utf8dw_out_if.
`default_nettype none

// Takes one byte of a UTF-8 string per word, with end_of_string on the
// string's last byte, and returns decoded code points with their display
// columns (0, 1 or 2) and the string's saturating running column sum.
// Malformed input turns into U+FFFD with replaced set: one per bad lead,
// one per held byte when a sequence breaks or the string ends inside it
// (the breaking byte is then decoded afresh), one per overlong, surrogate
// or out-of-range sequence. The last result of a string carries
// string_done, and the running sum restarts. A byte is decoded into a
// burst register in the cycle it is accepted; the burst drains into the
// output register one result per cycle unless the output stalls. A byte
// giving zero or one result holds the input only while the output stalls,
// so bytes otherwise stream at one per clock; a byte giving more results
// (at most 4) holds the input until its last one is loaded, set by the
// single result port. A byte's first result passes the burst register,
// then the output register; input ready depends combinationally on output ready.
module utf8_decode_display_width (
  input  wire                  clk,
  input  wire                  rst_n,
  utf8dw_in_if.sink            in_ch,
  utf8dw_out_if.source         out_ch
);
  import utf8dw_pkg::*;

  // decoder state
  seq_len_t         exp_r,  exp_nxt;
  logic [1:0]       held_r, held_nxt;
  logic [PartW-1:0] part_r, part_nxt;

  // burst register: replacement count for held bytes, then an optional tail
  logic       b_valid_r, b_valid_nxt;
  logic [1:0] b_rep_r,   b_rep_nxt;
  logic       b_tail_r,  b_tail_nxt;
  cp_t        b_cp_r,    b_cp_nxt;
  logic       b_bad_r,   b_bad_nxt;
  col_t       b_col_r,   b_col_nxt;
  logic       b_eos_r,   b_eos_nxt;

  // output register and running sum
  logic out_valid_r, out_valid_nxt;
  cp_t  out_cp_r,    out_cp_nxt;
  logic out_bad_r,   out_bad_nxt;
  col_t out_col_r,   out_col_nxt;
  tot_t out_tot_r,   out_tot_nxt;
  logic out_done_r,  out_done_nxt;
  tot_t run_r,       run_nxt;

  logic       in_acc;
  logic       in_ready;
  logic [7:0] byt;
  logic       eos;

  // fresh-byte decode
  logic             f_tail;
  cp_t              f_cp;
  logic             f_bad;
  seq_len_t         f_len;
  logic [PartW-1:0] f_bits;

  // per-byte burst
  logic [1:0] d_rep;
  logic       d_tail;
  cp_t        d_cp;
  logic       d_bad;
  logic       d_any;
  logic [2:0] cnt;
  cp_t        cp_cat;
  logic       seq_bad;

  // emission
  logic out_load;
  logic emit_repl;
  logic emit_last;
  logic emit_done;
  cp_t  emit_cp;
  logic emit_bad;
  col_t emit_col;
  logic [TotW:0] sum_ext;
  tot_t sum_sat;

  assign byt    = in_ch.data_byte;
  assign eos    = in_ch.end_of_string;
  assign in_acc = in_ch.valid && in_ready;

  always_comb begin
    f_tail = 1'b0;
    f_cp   = CP_REPL;
    f_bad  = 1'b0;
    f_len  = LEN_NONE;
    f_bits = '0;
    priority if (byt[7] == 1'b0) begin
      f_tail = 1'b1;
      f_cp   = {13'd0, byt};
    end else if (byt[7:5] == 3'b110) begin
      f_len  = LEN_TWO;
      f_bits = {10'd0, byt[4:0]};
    end else if (byt[7:4] == 4'b1110) begin
      f_len  = LEN_THREE;
      f_bits = {11'd0, byt[3:0]};
    end else if (byt[7:3] == 5'b11110) begin
      f_len  = LEN_FOUR;
      f_bits = {12'd0, byt[2:0]};
    end else begin
      f_tail = 1'b1;
      f_bad  = 1'b1;
    end
    // a lead that ends the string cannot complete
    if (f_len != LEN_NONE && eos) begin
      f_tail = 1'b1;
      f_bad  = 1'b1;
      f_cp   = CP_REPL;
      f_len  = LEN_NONE;
    end
  end

  always_comb begin
    cnt     = {1'b0, held_r} + 3'd1;
    cp_cat  = {part_r, byt[5:0]};
    seq_bad = (exp_r == LEN_TWO   && cp_cat < CP_MIN2) ||
              (exp_r == LEN_THREE && cp_cat < CP_MIN3) ||
              (exp_r == LEN_FOUR  && cp_cat < CP_MIN4) ||
              (cp_cat >= CP_SURR_LO && cp_cat <= CP_SURR_HI) ||
              (cp_cat > CP_MAX);
    d_rep    = 2'd0;
    d_tail   = f_tail;
    d_cp     = f_cp;
    d_bad    = f_bad;
    exp_nxt  = f_len;
    held_nxt = (f_len != LEN_NONE) ? 2'd1 : 2'd0;
    part_nxt = f_bits;
    if (exp_r != LEN_NONE) begin
      if (byt[7:6] == 2'b10) begin
        d_tail   = 1'b0;
        d_cp     = CP_REPL;
        d_bad    = 1'b0;
        exp_nxt  = LEN_NONE;
        held_nxt = 2'd0;
        part_nxt = '0;
        priority if (cnt >= exp_r) begin
          d_tail = 1'b1;
          d_bad  = seq_bad;
          d_cp   = seq_bad ? CP_REPL : cp_cat;
        end else if (eos) begin
          d_rep = cnt[1:0];
        end else begin
          exp_nxt  = exp_r;
          held_nxt = cnt[1:0];
          part_nxt = cp_cat[PartW-1:0];
        end
      end else begin
        // broken sequence: flush held bytes, then the fresh decode
        d_rep = held_r;
      end
    end
    if (eos) begin
      exp_nxt  = LEN_NONE;
      held_nxt = 2'd0;
      part_nxt = '0;
    end
    d_any = d_tail || (d_rep != 2'd0);
  end

  always_comb begin
    out_load  = b_valid_r && (!out_valid_r || out_ch.ready);
    emit_repl = (b_rep_r != 2'd0);
    emit_last = (b_rep_r == 2'd0) || (b_rep_r == 2'd1 && !b_tail_r);
    emit_done = emit_last && b_eos_r;
    emit_cp   = emit_repl ? CP_REPL : b_cp_r;
    emit_bad  = emit_repl ? 1'b1 : b_bad_r;
    emit_col  = emit_repl ? COL_ONE : b_col_r;
    sum_ext   = {1'b0, run_r} + {{(TotW-1){1'b0}}, emit_col};
    sum_sat   = sum_ext[TotW] ? {TotW{1'b1}} : sum_ext[TotW-1:0];
    in_ready  = !b_valid_r || (out_load && emit_last);

    b_valid_nxt = b_valid_r;
    b_rep_nxt   = b_rep_r;
    b_tail_nxt  = b_tail_r;
    b_cp_nxt    = b_cp_r;
    b_bad_nxt   = b_bad_r;
    b_col_nxt   = b_col_r;
    b_eos_nxt   = b_eos_r;
    priority if (in_acc && d_any) begin
      b_valid_nxt = 1'b1;
      b_rep_nxt   = d_rep;
      b_tail_nxt  = d_tail;
      b_cp_nxt    = d_cp;
      b_bad_nxt   = d_bad;
      b_col_nxt   = col_class(d_cp);
      b_eos_nxt   = eos;
    end else if (out_load && emit_last) begin
      b_valid_nxt = 1'b0;
    end else if (out_load) begin
      b_rep_nxt = b_rep_r - 2'd1;
    end else begin
      b_valid_nxt = b_valid_r;
    end

    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    out_cp_nxt    = out_load ? emit_cp   : out_cp_r;
    out_bad_nxt   = out_load ? emit_bad  : out_bad_r;
    out_col_nxt   = out_load ? emit_col  : out_col_r;
    out_tot_nxt   = out_load ? sum_sat   : out_tot_r;
    out_done_nxt  = out_load ? emit_done : out_done_r;
    run_nxt       = out_load ? (emit_done ? '0 : sum_sat) : run_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= LEN_NONE;
      held_r      <= 2'd0;
      part_r      <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      run_r       <= '0;
    end else begin
      if (in_acc) begin
        exp_r  <= exp_nxt;
        held_r <= held_nxt;
        part_r <= part_nxt;
      end
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_rep_r    <= b_rep_nxt;
    b_tail_r   <= b_tail_nxt;
    b_cp_r     <= b_cp_nxt;
    b_bad_r    <= b_bad_nxt;
    b_col_r    <= b_col_nxt;
    b_eos_r    <= b_eos_nxt;
    out_cp_r   <= out_cp_nxt;
    out_bad_r  <= out_bad_nxt;
    out_col_r  <= out_col_nxt;
    out_tot_r  <= out_tot_nxt;
    out_done_r <= out_done_nxt;
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_point   = out_cp_r;
  assign out_ch.replaced     = out_bad_r;
  assign out_ch.column_width = out_col_r;
  assign out_ch.col_total    = out_tot_r;
  assign out_ch.string_done  = out_done_r;

  // an open sequence holds between one and length-1 bytes
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r == LEN_NONE) ? (held_r == 2'd0)
                        : (held_r != 2'd0 && {1'b0, held_r} < exp_r))
    else $error("decoder held count out of range");

  // the end of a string leaves no sequence open
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && eos |=> exp_r == LEN_NONE)
    else $error("sequence still open after end of string");

  // a finished string restarts the column sum
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && emit_done |=> run_r == '0)
    else $error("running width not cleared after string end");

  // within a string the sum never falls
  a_sum_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !emit_done |=> run_r >= $past(run_r))
    else $error("running width decreased within a string");

  // a pending burst always has a result left to give
  a_burst_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_rep_r != 2'd0 || b_tail_r))
    else $error("empty burst held");

endmodule

`default_nettype wire

@@ dv/utf8_decode_display_width_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for utf8_decode_display_width: streams directed and random
// UTF-8 text with end-of-string marks and checks every decoded word in order.
// Depends on utf8dw_pkg, utf8dw_in_if, utf8dw_out_if and the top level.

module utf8_decode_display_width_tb;
  import utf8dw_pkg::*;

  typedef struct {
    cp_t  code_point;
    logic replaced;
    col_t cols;
    tot_t total;
    logic done;
  } char_t;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    char_t      want;
  } row_t;

  localparam int NEdge = 64;
  localparam int HoldCycles = 200;
  localparam int PhaseItems = 64;

  // Range-table borders and other interesting code points
  localparam cp_t EDGE_CPS [NEdge] = '{
    21'h00000, 21'h0001F, 21'h00020, 21'h0007E, 21'h0007F, 21'h0009F, 21'h000A0, 21'h002FF,
    21'h00300, 21'h0036F, 21'h00370, 21'h01AAF, 21'h01AB0, 21'h01DFF, 21'h01E00, 21'h0200B,
    21'h0200D, 21'h0200E, 21'h02060, 21'h02061, 21'h020D0, 21'h020FF, 21'h02E7F, 21'h02E80,
    21'h02FDF, 21'h02FE0, 21'h02FF0, 21'h0A4CF, 21'h0A4D0, 21'h0A960, 21'h0A97F, 21'h0AC00,
    21'h0D7FF, 21'h0F8FF, 21'h0F900, 21'h0FAFF, 21'h0FE0E, 21'h0FE0F, 21'h0FE10, 21'h0FE1F,
    21'h0FE20, 21'h0FE2F, 21'h0FE30, 21'h0FE6F, 21'h0FE70, 21'h0FEFF, 21'h0FF00, 21'h0FF60,
    21'h0FF61, 21'h0FFE0, 21'h0FFE6, 21'h0FFE7, 21'h0FFFD, 21'h1F0FF, 21'h1F100, 21'h1F1FF,
    21'h1F200, 21'h1F300, 21'h1FBFF, 21'h1FC00, 21'h20000, 21'h3FFFF, 21'h40000, 21'h10FFFF};

  logic clk = 1'b0;
  logic rst_n;

  utf8dw_in_if  in_ch ();
  utf8dw_out_if out_ch ();

  utf8_decode_display_width uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Decoder state mirrored by the predictor
  seq_len_t   seq_len;
  logic [1:0] held;
  cp_t        part;
  tot_t       run_total;

  char_t      step_chars[$];
  char_t      chars_due[$];
  row_t       dir_rows[$];
  logic [7:0] text_bytes[$];
  char_t      no_char;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_tokens;
  int items_sent;
  int mismatches;

  function automatic col_t cols_of(cp_t cp);
    if (cp <= 21'h001F || (cp >= 21'h007F && cp <= 21'h009F) ||
        (cp >= 21'h0300 && cp <= 21'h036F) || (cp >= 21'h1AB0 && cp <= 21'h1AFF) ||
        (cp >= 21'h1DC0 && cp <= 21'h1DFF) || (cp >= 21'h200B && cp <= 21'h200D) ||
        cp == 21'h2060 || (cp >= 21'h20D0 && cp <= 21'h20FF) ||
        (cp >= 21'hFE0E && cp <= 21'hFE0F) || (cp >= 21'hFE20 && cp <= 21'hFE2F) ||
        cp == 21'hFEFF)
      return COL_ZERO;
    if ((cp >= 21'h2E80 && cp <= 21'h2FDF) || (cp >= 21'h2FF0 && cp <= 21'hA4CF) ||
        (cp >= 21'hA960 && cp <= 21'hA97F) || (cp >= 21'hAC00 && cp <= 21'hD7FF) ||
        (cp >= 21'hF900 && cp <= 21'hFAFF) || (cp >= 21'hFE10 && cp <= 21'hFE1F) ||
        (cp >= 21'hFE30 && cp <= 21'hFE6F) || (cp >= 21'hFF00 && cp <= 21'hFF60) ||
        (cp >= 21'hFFE0 && cp <= 21'hFFE6) || (cp >= 21'h1F100 && cp <= 21'h1F1FF) ||
        (cp >= 21'h1F300 && cp <= 21'h1FBFF) || (cp >= 21'h20000 && cp <= 21'h3FFFF))
      return COL_TWO;
    return COL_ONE;
  endfunction

  task automatic add_char(cp_t cp, logic bad);
    char_t c;
    col_t  w;
    w = cols_of(cp);
    if (run_total > 32'hFFFF_FFFF - w) run_total = '1;
    else run_total = run_total + w;
    c.code_point = cp;
    c.replaced   = bad;
    c.cols       = w;
    c.total      = run_total;
    c.done       = 1'b0;
    step_chars.push_back(c);
  endtask

  task automatic clear_seq();
    seq_len = LEN_NONE;
    held    = '0;
    part    = '0;
  endtask

  task automatic start_char(logic [7:0] b, logic eos);
    seq_len_t len;
    cp_t      lead_bits;
    len       = LEN_NONE;
    lead_bits = '0;
    if (!b[7]) begin
      add_char(cp_t'(b), 1'b0);
    end else begin
      if (b[7:5] == 3'b110) begin
        len = LEN_TWO;
        lead_bits = cp_t'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        len = LEN_THREE;
        lead_bits = cp_t'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        len = LEN_FOUR;
        lead_bits = cp_t'(b[2:0]);
      end
      // a bad lead, or a good lead with nothing after it, is one replacement
      if (len == LEN_NONE || eos) begin
        add_char(CP_REPL, 1'b1);
      end else begin
        seq_len = len;
        held    = 2'd1;
        part    = lead_bits;
      end
    end
  endtask

  task automatic decode_byte(logic [7:0] b, logic eos);
    int unsigned n_held;
    cp_t         cp;
    logic        bad;
    char_t       last;
    step_chars.delete();
    if (seq_len == LEN_NONE) begin
      start_char(b, eos);
    end else if (b[7:6] == 2'b10) begin
      n_held = 32'(held) + 32'd1;
      cp = cp_t'({part, b[5:0]});
      if (n_held >= seq_len) begin
        bad = (seq_len == LEN_TWO && cp < CP_MIN2) || (seq_len == LEN_THREE && cp < CP_MIN3) ||
              (seq_len == LEN_FOUR && cp < CP_MIN4) ||
              (cp >= CP_SURR_LO && cp <= CP_SURR_HI) || (cp > CP_MAX);
        clear_seq();
        add_char(bad ? CP_REPL : cp, bad);
      end else if (eos) begin
        clear_seq();
        repeat (n_held) add_char(CP_REPL, 1'b1);
      end else begin
        held = n_held[1:0];
        part = cp;
      end
    end else begin
      // flush every held byte, then decode the breaking byte afresh
      n_held = 32'(held);
      clear_seq();
      repeat (n_held) add_char(CP_REPL, 1'b1);
      start_char(b, eos);
    end
    if (eos) begin
      if (step_chars.size() > 0) begin
        last = step_chars.pop_back();
        last.done = 1'b1;
        step_chars.push_back(last);
      end
      clear_seq();
      run_total = '0;
    end
  endtask

  function automatic logic [7:0] cont_byte();
    logic [5:0] r;
    r = 6'($urandom);
    return {2'b10, r};
  endfunction

  function automatic cp_t pick_cp();
    cp_t cp;
    case ($urandom_range(0, 4))
      0: cp = cp_t'($urandom_range(0, 'h7F));
      1: cp = cp_t'($urandom_range('h80, 'h7FF));
      2: begin
        cp = cp_t'($urandom_range('h800, 'hFFFF));
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp + 21'h800;
      end
      3: cp = cp_t'($urandom_range('h10000, 'h10FFFF));
      default: cp = EDGE_CPS[$urandom_range(0, NEdge - 1)];
    endcase
    return cp;
  endfunction

  task automatic push_cp(cp_t cp);
    if (cp < CP_MIN2) begin
      text_bytes.push_back(cp[7:0]);
    end else if (cp < CP_MIN3) begin
      text_bytes.push_back({3'b110, cp[10:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < CP_MIN4) begin
      text_bytes.push_back({4'b1110, cp[15:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      text_bytes.push_back({5'b11110, cp[20:18]});
      text_bytes.push_back({2'b10, cp[17:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  // Complete sequences that must decode to a single replacement
  task automatic push_bad_form();
    logic [5:0] r6;
    r6 = 6'($urandom);
    case ($urandom_range(0, 4))
      0: begin
        text_bytes.push_back({7'b1100000, r6[0]});
        text_bytes.push_back(cont_byte());
      end
      1: begin
        text_bytes.push_back(8'hE0);
        text_bytes.push_back({3'b100, r6[4:0]});
        text_bytes.push_back(cont_byte());
      end
      2: begin
        text_bytes.push_back(8'hF0);
        text_bytes.push_back({4'b1000, r6[3:0]});
        text_bytes.push_back(cont_byte());
        text_bytes.push_back(cont_byte());
      end
      3: begin
        text_bytes.push_back(8'hED);
        text_bytes.push_back({3'b101, r6[4:0]});
        text_bytes.push_back(cont_byte());
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          text_bytes.push_back(8'hF4);
          r6 = 6'($urandom_range(16, 63));
          text_bytes.push_back({2'b10, r6});
        end else begin
          r6 = 6'($urandom_range(5, 7));
          text_bytes.push_back({5'b11110, r6[2:0]});
          text_bytes.push_back(cont_byte());
        end
        text_bytes.push_back(cont_byte());
        text_bytes.push_back(cont_byte());
      end
    endcase
  endtask

  task automatic build_text();
    int  units;
    int  kind;
    int  len;
    cp_t cp;
    text_bytes.delete();
    units = $urandom_range(1, 8);
    repeat (units) begin
      kind = $urandom_range(0, 99);
      if (kind < 64) begin
        push_cp(pick_cp());
      end else if (kind < 76) begin
        push_bad_form();
      end else if (kind < 88) begin
        // truncated sequence: the next unit or the string end breaks it
        cp = pick_cp();
        if (cp < CP_MIN2) cp = cp + CP_MIN2;
        len = (cp < CP_MIN3) ? 2 : (cp < CP_MIN4) ? 3 : 4;
        push_cp(cp);
        repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
      end else begin
        text_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic eos, logic typed, char_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_string <= eos;
    do @(posedge clk); while (!in_ch.ready);
    decode_byte(b, eos);
    if (typed) chars_due.push_back(want);
    else foreach (step_chars[i]) chars_due.push_back(step_chars[i]);
    items_sent++;
  endtask

  // Hold the input until every expected word has been taken
  task automatic drain_words();
    in_ch.valid <= 1'b0;
    while (chars_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic dir_row(logic [7:0] b, logic eos);
    row_t r;
    r.data  = b;
    r.eos   = eos;
    r.typed = 1'b0;
    r.want  = no_char;
    dir_rows.push_back(r);
  endtask

  task automatic dir_typed(logic [7:0] b, logic eos, cp_t cp, logic rep, col_t cols,
                           tot_t tot, logic done);
    row_t r;
    r.data            = b;
    r.eos             = eos;
    r.typed           = 1'b1;
    r.want.code_point = cp;
    r.want.replaced   = rep;
    r.want.cols       = cols;
    r.want.total      = tot;
    r.want.done       = done;
    dir_rows.push_back(r);
  endtask

  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_tokens) begin
        hold_seen = hold_tokens;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : word_check
    char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (chars_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word cp %h rep %b cols %0d total %0d done %b", $time,
                   out_ch.code_point, out_ch.replaced, out_ch.column_width,
                   out_ch.col_total, out_ch.string_done);
      end else begin
        want = chars_due.pop_front();
        if (out_ch.code_point !== want.code_point || out_ch.replaced !== want.replaced ||
            out_ch.column_width !== want.cols || out_ch.col_total !== want.total ||
            out_ch.string_done !== want.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: word mismatch (exp/act) cp %h/%h rep %b/%b cols %0d/%0d %s%0d/%0d %s%b/%b",
                     $time, want.code_point, out_ch.code_point, want.replaced, out_ch.replaced,
                     want.cols, out_ch.column_width, "total ", want.total, out_ch.col_total,
                     "done ", want.done, out_ch.string_done);
        end
      end
    end
  end

  initial begin
    int phase;
    int phase_start;
    bit held_off;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_string <= 1'b0;
    clear_seq();
    run_total      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    held_off       = 1'b0;

    // byte, end, then the expected word where it is plain to see
    dir_typed(8'h00, 1'b0, 21'h0, 1'b0, COL_ZERO, 32'd0, 1'b0);
    dir_typed(8'h80, 1'b0, CP_REPL, 1'b1, COL_ONE, 32'd1, 1'b0);
    dir_typed(8'hFF, 1'b1, CP_REPL, 1'b1, COL_ONE, 32'd2, 1'b1);
    dir_row(8'hC2, 1'b0); dir_row(8'h80, 1'b0);
    dir_row(8'hE4, 1'b0); dir_row(8'hB8, 1'b0); dir_row(8'h80, 1'b0);
    dir_row(8'hEF, 1'b0); dir_row(8'hBF, 1'b0); dir_row(8'hBD, 1'b0);
    dir_row(8'hF7, 1'b0); dir_row(8'hBF, 1'b0); dir_row(8'hBF, 1'b0); dir_row(8'hBF, 1'b0);
    dir_row(8'hED, 1'b0); dir_row(8'hA0, 1'b0); dir_row(8'h80, 1'b0);
    dir_row(8'hC0, 1'b0); dir_row(8'h80, 1'b0);
    dir_row(8'hF0, 1'b0); dir_row(8'h90, 1'b0); dir_row(8'h80, 1'b0); dir_row(8'h41, 1'b1);
    dir_row(8'hE4, 1'b0); dir_row(8'hB8, 1'b1);
    dir_typed(8'hC2, 1'b1, CP_REPL, 1'b1, COL_ONE, 32'd1, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].want);
    drain_words();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        build_text();
        // long receiver hold-off while bytes keep coming
        if (phase == 0 && !held_off && items_sent - phase_start >= 20) begin
          hold_tokens++;
          held_off = 1'b1;
        end
        foreach (text_bytes[i])
          send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, no_char);
      end
      drain_words();
    end

    if (mismatches == 0 && chars_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
hdl/utf8dw_pkg.sv
hdl/utf8dw_in_if.sv
hdl/utf8dw_out_if.sv
hdl/utf8_decode_display_width.sv
dv/utf8_decode_display_width_tb.sv
